### hdl/rational_arith_reduce_defines.svh
// Assertion macros used by the bound checker in rar_checker.sv.
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define RAR_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Implication checked in the cycle after its precondition.
`define RAR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

### hdl/rar_pkg.sv
package rar_pkg;
   localparam int OPERAND_WIDTH = 16;
   localparam int PW = 2 * OPERAND_WIDTH + 2;   // raw value width, sign included
   localparam int NUM_W = 33;
   localparam int DEN_W = 32;
   localparam int CNT_W = $clog2(PW + 1);

   typedef enum logic [1:0] {
      OP_ADD = 2'd0, OP_SUB = 2'd1, OP_MUL = 2'd2, OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      op_type                           operation;
      logic signed [OPERAND_WIDTH-1:0] first_numerator;
      logic signed [OPERAND_WIDTH-1:0] first_denominator;
      logic signed [OPERAND_WIDTH-1:0] second_numerator;
      logic signed [OPERAND_WIDTH-1:0] second_denominator;
   } req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] result_numerator;
      logic signed [DEN_W-1:0] result_denominator;
      logic                    zero_divisor_fault;
   } rsp_type;

   // Divider operand selection.
   typedef enum logic [1:0] {
      DSEL_EUCLID = 2'd0, DSEL_NUM = 2'd1, DSEL_DEN = 2'd2
   } dsel_type;

   typedef struct packed {
      logic     load;        // capture request
      logic     mul2;        // form all three products
      logic     form;        // form raw values, seed Euclid pair
      logic     div_start;
      dsel_type div_sel;
      logic     euclid_step; // (x,y) <= (y, rem)
      logic     save_num;
      logic     save_den;
   } cmd_type;

   typedef struct packed {
      logic y_zero;
      logic div_done;
   } sts_type;
endpackage

### hdl/rar_divider.sv
module rar_divider
   import rar_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [PW-1:0] dividend,
   input  logic signed [PW-1:0] divisor,
   output logic                 done,
   output logic signed [PW-1:0] quotient,
   output logic signed [PW-1:0] remainder
);
   // Restoring shift-subtract divider, one quotient bit per cycle on magnitudes.
   logic [PW-1:0]    q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic             qn_ff, qn_in, rn_ff, rn_in, busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PW:0]      trial;
   logic             fin_ff;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; qn_in = qn_ff; rn_in = rn_ff;
      busy_in = busy_ff; cnt_in = cnt_ff;
      trial = {1'b0, r_ff[PW-2:0], q_ff[PW-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend[PW-1] ? -dividend : dividend;
         d_in = divisor[PW-1] ? -divisor : divisor;
         r_in = '0;
         qn_in = dividend[PW-1] ^ divisor[PW-1];
         rn_in = dividend[PW-1];
         busy_in = 1'b1;
         cnt_in = CNT_W'(PW);
      end else if (busy_ff) begin
         if (!trial[PW]) begin
            r_in = trial[PW-1:0];
            q_in = {q_ff[PW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[PW-2:0], q_ff[PW-1]};
            q_in = {q_ff[PW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; qn_ff <= qn_in; rn_ff <= rn_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= busy_ff && !busy_in;
      end
   end

   assign quotient  = qn_ff ? -q_ff : q_ff;
   assign remainder = rn_ff ? -r_ff : r_ff;
   assign done      = fin_ff;
endmodule

### hdl/rar_datapath.sv
module rar_datapath
   import rar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);
   localparam int MW = 2 * OPERAND_WIDTH;
   req_type             req_ff;
   logic signed [MW-1:0] p1_ff, p2_ff, p3_ff;
   logic signed [PW-1:0] n_ff, d_ff, x_ff, y_ff;
   logic signed [PW-1:0] dv_a, dv_b, quo, rem;
   logic                 dv_done;
   rsp_type              rsp_ff;
   logic signed [OPERAND_WIDTH-1:0] m1a, m1b, m2a, m2b;

   // Three multipliers used in one step: a*d (or a*c), b*d (or b*c) and c*b.
   always_comb begin
      m1a = req_ff.first_numerator;
      m1b = (req_ff.operation == OP_MUL) ? req_ff.second_numerator
                                         : req_ff.second_denominator;
      m2a = req_ff.first_denominator;
      m2b = (req_ff.operation == OP_DIV) ? req_ff.second_numerator
                                         : req_ff.second_denominator;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req;
      if (cmd.mul2) begin
         p1_ff <= m1a * m1b;
         p2_ff <= m2a * m2b;
         p3_ff <= req_ff.second_numerator * req_ff.first_denominator;
      end
      if (cmd.form) begin
         unique case (req_ff.operation)
            OP_ADD:  n_ff <= PW'(p1_ff) + PW'(p3_ff);
            OP_SUB:  n_ff <= PW'(p1_ff) - PW'(p3_ff);
            default: n_ff <= PW'(p1_ff);
         endcase
         d_ff <= PW'(p2_ff);
         x_ff <= (req_ff.operation == OP_SUB || req_ff.operation == OP_ADD)
                 ? ((req_ff.operation == OP_ADD) ? PW'(p1_ff) + PW'(p3_ff)
                                                 : PW'(p1_ff) - PW'(p3_ff))
                 : PW'(p1_ff);
         y_ff <= PW'(p2_ff);
      end
      if (cmd.euclid_step) begin
         x_ff <= y_ff;
         y_ff <= rem;
      end
      if (cmd.save_num) begin
         rsp_ff.result_numerator   <= (x_ff == '0) ? '0 : NUM_W'(quo);
         rsp_ff.zero_divisor_fault <= (x_ff == '0);
      end
      if (cmd.save_den) rsp_ff.result_denominator <= (x_ff == '0) ? '0 : DEN_W'(quo);
   end

   always_comb begin
      unique case (cmd.div_sel)
         DSEL_NUM: begin dv_a = n_ff; dv_b = (x_ff == '0) ? PW'(1) : x_ff; end
         DSEL_DEN: begin dv_a = d_ff; dv_b = (x_ff == '0) ? PW'(1) : x_ff; end
         default:  begin dv_a = x_ff; dv_b = y_ff; end
      endcase
   end

   rar_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(dv_a), .divisor(dv_b),
      .done(dv_done), .quotient(quo), .remainder(rem)
   );

   assign sts.y_zero   = (y_ff == '0);
   assign sts.div_done = dv_done;
   assign rsp = rsp_ff;
endmodule

### hdl/rar_control.sv
module rar_control
   import rar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001, S_MUL = 8'b0000_0010, S_FORM = 8'b0000_0100,
      S_TEST = 8'b0000_1000, S_EDIV = 8'b0001_0000, S_NDIV = 8'b0010_0000,
      S_DDIV = 8'b0100_0000, S_OUT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      wait_ff, wait_in;   // divider launched, waiting for done

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      cmd      = '0;
      cmd.div_sel = DSEL_EUCLID;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin cmd.load = 1'b1; state_in = S_MUL; end
         S_MUL:  begin cmd.mul2 = 1'b1; state_in = S_FORM; end
         S_FORM: begin cmd.form = 1'b1; state_in = S_TEST; end
         S_TEST: begin
            if (sts.y_zero) state_in = S_NDIV;
            else state_in = S_EDIV;
            wait_in = 1'b0;
         end
         S_EDIV: begin
            if (!wait_ff) begin cmd.div_start = 1'b1; wait_in = 1'b1; end
            else if (sts.div_done) begin
               cmd.euclid_step = 1'b1; state_in = S_TEST;
            end
         end
         S_NDIV: begin
            cmd.div_sel = DSEL_NUM;
            if (!wait_ff) begin cmd.div_start = 1'b1; wait_in = 1'b1; end
            else if (sts.div_done) begin
               cmd.save_num = 1'b1; wait_in = 1'b0; state_in = S_DDIV;
            end
         end
         S_DDIV: begin
            cmd.div_sel = DSEL_DEN;
            if (!wait_ff) begin cmd.div_start = 1'b1; wait_in = 1'b1; end
            else if (sts.div_done) begin
               cmd.save_den = 1'b1; wait_in = 1'b0; state_in = S_OUT;
            end
         end
         S_OUT:  if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
endmodule

### hdl/rational_arith_reduce.sv
// Reduces the sum, difference, product or quotient of two signed 16-bit
// fractions by the signed greatest common divisor of the raw 34-bit result.
// One request is taken at a time. A request is taken, its products and raw
// values are formed and the Euclid pair is tested; each Euclid remainder step
// then runs in the shared shift-subtract divider, followed by the two final
// divides and the handover of the response. The response is held until taken.
// A zero greatest common divisor (both raw values zero) returns 0/0 with the
// fault flag set.
module rational_arith_reduce
   import rar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   cmd_type cmd;
   sts_type sts;

   // The controller sequences; the datapath holds operands and the divider.
   rar_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   rar_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .sts(sts),
      .rsp(rsp_data)
   );
endmodule

### hdl/rar_checker.sv
`include "rational_arith_reduce_defines.svh"
module rar_checker
   import rar_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   logic fault_shown, zero_shown;

   assign fault_shown = rsp_valid && rsp_data.zero_divisor_fault;
   assign zero_shown  = (rsp_data.result_numerator == '0)
                        && (rsp_data.result_denominator == '0);

   // Only one request in flight: busy while a response is pending.
   `RAR_ASSERT_IMPLY(a_stall_busy, clock, reset, rsp_valid, req_stall)
   // A fault response always reports 0/0.
   `RAR_ASSERT_IMPLY(a_fault_zero, clock, reset, fault_shown, zero_shown)
   // Accepting a request makes the block busy next cycle.
   `RAR_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall && !rsp_valid)
   // A stalled response holds.
   `RAR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
endmodule

bind rational_arith_reduce rar_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

### tb/sv/rational_arith_reduce_checker.sv
`timescale 1ns / 100ps

// Watches both channels of rational_arith_reduce, computes the reduced
// fraction for each accepted request and compares it with the responses.
module rational_arith_reduce_checker
   import rar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count,
   output int      response_count
);

   rsp_type expected_fractions[$];

   function automatic rsp_type reduce_fraction(req_type r);
      logic signed [63:0] a, b, c, d, n, den, x, y, t, g;
      rsp_type res;
      a = 64'(r.first_numerator);
      b = 64'(r.first_denominator);
      c = 64'(r.second_numerator);
      d = 64'(r.second_denominator);
      case (r.operation)
         OP_ADD: begin n = a * d + c * b; den = b * d; end
         OP_SUB: begin n = a * d - c * b; den = b * d; end
         OP_MUL: begin n = a * c; den = b * d; end
         default: begin n = a * d; den = b * c; end
      endcase
      x = n;
      y = den;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      g = x;
      res.zero_divisor_fault = (g == 0);
      if (g == 0) begin
         res.result_numerator = '0;
         res.result_denominator = '0;
      end else begin
         res.result_numerator = NUM_W'(n / g);
         res.result_denominator = DEN_W'(den / g);
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      response_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_fractions.push_back(reduce_fraction(req_data));
         if (rsp_valid && !rsp_stall) begin
            response_count++;
            if (expected_fractions.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_data), 64'd0);
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_data.result_numerator !== want.result_numerator)
                  report_mismatch("numerator", 64'(rsp_data.result_numerator),
                                  64'(want.result_numerator));
               if (rsp_data.result_denominator !== want.result_denominator)
                  report_mismatch("denominator", 64'(rsp_data.result_denominator),
                                  64'(want.result_denominator));
               if (rsp_data.zero_divisor_fault !== want.zero_divisor_fault)
                  report_mismatch("fault", 64'(rsp_data.zero_divisor_fault),
                                  64'(want.zero_divisor_fault));
            end
         end
         pending_count = expected_fractions.size();
      end
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

// Top of the fraction reducer testbench. It drives requests in bursts, stalls
// the response side on its own pattern and leaves all checking to the
// checker instance, which reports its failure count back here.
module tb;
   import rar_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      error_count, pending_count, response_count;
   int      request_count = 0;
   bit      driving_done = 1'b0;

   always #5 clock = ~clock;

   rational_arith_reduce dut (.*);
   rational_arith_reduce_checker checker_inst (.*);

   // Operand picker: mostly random, with a good share of edge values so that
   // zeros, extremes and shared factors come up often.
   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 8)) - 4);
         4: return 16'(($urandom_range(0, 255) - 128) * 64);
         default: return 16'($urandom);
      endcase
   endfunction

   // Presents one request from the falling edge and holds it until accepted.
   // The valid stays high across back-to-back requests of a burst.
   task automatic send_request(op_type op, logic [15:0] a, logic [15:0] b,
                               logic [15:0] c, logic [15:0] d, bit keep_valid);
      req_data.operation <= op;
      req_data.first_numerator <= a;
      req_data.first_denominator <= b;
      req_data.second_numerator <= c;
      req_data.second_denominator <= d;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      request_count++;
      @(negedge clock);
      if (!keep_valid) req_valid <= 1'b0;
   endtask

   // The receiver alternates between quiet stretches and random stalling.
   initial begin
      int mode;
      mode = 0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   initial begin
      int burst, waited;
      logic [15:0] ext[4];
      ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every operation on the extreme operands, then named cases.
      for (int op = 0; op < 4; op++) begin
         send_request(op_type'(op), ext[op], ext[(op+1)%4], ext[(op+2)%4], ext[(op+3)%4], 0);
      end
      send_request(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
      send_request(OP_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
      send_request(OP_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
      // Both raw values zero gives the fault.
      send_request(OP_ADD, 16'h0000, 16'h0000, 16'h0005, 16'h0000, 0);
      send_request(OP_MUL, 16'h0000, 16'h0003, 16'h0007, 16'h0000, 0);
      // Zero raw denominator with a nonzero numerator reduces to one over zero.
      send_request(OP_MUL, 16'h0003, 16'h0000, 16'h0007, 16'h0002, 0);
      send_request(OP_DIV, 16'hfffd, 16'h0004, 16'h0000, 16'h0005, 0);
      // Negative divisor flips both signs.
      send_request(OP_SUB, 16'h0001, 16'hfffe, 16'h0001, 16'h0003, 0);
      send_request(OP_DIV, 16'h0006, 16'h0004, 16'hfff7, 16'h000c, 0);
      send_request(OP_SUB, 16'h1234, 16'h0011, 16'h1234, 16'h0011, 0);
      send_request(OP_ADD, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0);

      // Random bursts, mostly with gaps between them.
      while (request_count < 1900) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst; i++) begin
            send_request(op_type'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                         pick_operand(), pick_operand(), i < burst - 1);
         end
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(negedge clock);
      end
      driving_done = 1'b1;

      waited = 0;
      while (pending_count != 0 && waited < 4000000) begin
         @(posedge clock);
         waited++;
      end
      repeat (2000) @(posedge clock);
      $display("covered %0d requests over all four operations, %0d responses checked",
               request_count, response_count);
      $display("directed cases included extreme operands, zero divisors and sign flips");
      if (error_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Long watchdog: the worst-case time for about 1900 requests, plus response
   // stalls, taken several times over.
   initial begin
      #200ms;
      $display("timeout waiting for responses");
      $display("status: fail");
      $finish;
   end

endmodule
